// ===== hdl/log_frequency_glide_defines.svh =====
// Assertion macros for the glide block
`ifndef LOG_FREQUENCY_GLIDE_DEFINES_SVH
`define LOG_FREQUENCY_GLIDE_DEFINES_SVH
// assert that a implies b in the next cycle
`define LFG_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("label failed");
// assert that a implies b in the same cycle
`define LFG_ASSERT_NOW(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("label failed");
`endif

// ===== hdl/lfg_pkg.sv =====
// Package: constants, types and state codes for the glide block
package lfg_pkg;
  localparam int LOG_FRAC_BITS_DEF = 40;
  localparam int COUNT_BITS_DEF    = 32;
  localparam logic [1:0] ACT_RESET = 2'd0;
  localparam logic [1:0] ACT_SET   = 2'd1;
  localparam logic [1:0] ACT_TRANS = 2'd2;
  localparam logic [1:0] ACT_NEXT  = 2'd3;
  localparam logic [1:0] REG_RATE  = 2'd0;
  localparam logic [1:0] REG_TIME  = 2'd1;
  localparam logic [1:0] REG_MODE  = 2'd2;
  localparam logic [1:0] MODE_ALWAYS = 2'd1;
  localparam logic [1:0] MODE_LEGATO = 2'd2;
  localparam logic [18:0] RATE_DEFAULT = 19'd44100;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOG, ST_LOGSQ, ST_LEN, ST_DIV, ST_EXP, ST_EXPSQ, ST_EXPMUL,
    ST_OUT
  } state_t;
endpackage

// ===== hdl/lfg_mul.sv =====
// Shift-add multiplier, one bit of the multiplier per cycle
module lfg_mul import lfg_pkg::*; #(
  parameter int W = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic           done,
  output logic [2*W-1:0] p
);
  localparam int CW = $clog2(W + 1);
  logic [2*W-1:0] acc_r, acc_nxt;
  logic [2*W-1:0] mc_r, mc_nxt;
  logic [W-1:0]   mp_r, mp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    acc_nxt = acc_r; mc_nxt = mc_r; mp_nxt = mp_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      acc_nxt = '0; mc_nxt = {{W{1'b0}}, a}; mp_nxt = b;
      cnt_nxt = CW'(W); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mp_r[0]) acc_nxt = acc_r + mc_r;
      mc_nxt = mc_r << 1;
      mp_nxt = mp_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt; mc_r <= mc_nxt; mp_r <= mp_nxt;
  end

  assign done = done_r;
  assign p    = acc_r;
endmodule

// ===== hdl/lfg_div.sv =====
// Restoring divider and integer square root, one quotient bit per cycle
module lfg_div import lfg_pkg::*; #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic         sqrt_mode,
  input  logic [W-1:0] n,
  input  logic [W-1:0] d,
  output logic         done,
  output logic [W-1:0] q
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0]  num_r, num_nxt, den_r, den_nxt, rem_r, rem_nxt, q_r, q_nxt;
  logic [W-1:0]  bit_r, bit_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt, sq_r, sq_nxt;
  logic [W:0]    trial;
  logic [W-1:0]  rsh;

  always_comb begin
    num_nxt = num_r; den_nxt = den_r; rem_nxt = rem_r; q_nxt = q_r;
    bit_nxt = bit_r; cnt_nxt = cnt_r; busy_nxt = busy_r; sq_nxt = sq_r;
    done_nxt = 1'b0;
    rsh = {rem_r[W-2:0], num_r[W-1]};
    trial = '0;
    if (start) begin
      num_nxt = n; den_nxt = d; rem_nxt = '0; q_nxt = '0; sq_nxt = sqrt_mode;
      bit_nxt = {2'b01, {(W-2){1'b0}}};
      cnt_nxt = sqrt_mode ? CW'(W / 2) : CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sq_r) begin
        // num holds v, q holds res
        trial = {1'b0, num_r} - {1'b0, q_r | bit_r};
        if (!trial[W]) begin
          num_nxt = trial[W-1:0];
          q_nxt = (q_r >> 1) | bit_r;
        end else begin
          q_nxt = q_r >> 1;
        end
        bit_nxt = bit_r >> 2;
      end else begin
        trial = {1'b0, rsh} - {1'b0, den_r};
        num_nxt = num_r << 1;
        if (!trial[W]) begin
          rem_nxt = trial[W-1:0]; q_nxt = {q_r[W-2:0], 1'b1};
        end else begin
          rem_nxt = rsh; q_nxt = {q_r[W-2:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    num_r <= num_nxt; den_r <= den_nxt; rem_r <= rem_nxt; q_r <= q_nxt;
    bit_r <= bit_nxt; sq_r <= sq_nxt;
  end

  assign done = done_r;
  assign q    = q_r;
endmodule

// ===== hdl/log_frequency_glide.sv =====
// Top level: log2-domain portamento glide with serial arithmetic units
// Sequence: set/transition words run log2 (40 squarings), then for a gliding transition
//   the length product and the step divide, then exp2 (40 square roots and up to 40
//   multiplies); next-sample words run exp2 only; reset words and words with nothing held skip it.
// Throughput: one word at a time; the next word is taken once the result has left.
// Reset: synchronous active-low rst_n clears glide state and restores register defaults.
module log_frequency_glide import lfg_pkg::*; #(
  parameter int LOG_FRAC_BITS = LOG_FRAC_BITS_DEF,
  parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [23:0] in_frequency,
  input  logic        in_legato,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] out_frequency_out,
  output logic        out_gliding,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int LW = LOG_FRAC_BITS + 5;
  localparam int SW = LOG_FRAC_BITS + 6;
  localparam int FB = $clog2(LOG_FRAC_BITS + 1);
  localparam int S  = LOG_FRAC_BITS + 16;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [18:0] rate_r; logic [23:0] tpo_r; logic [1:0] mode_r;
  logic [LW-1:0] cur_r, cur_nxt, tgt_r, tgt_nxt, tl_r, tl_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [COUNT_BITS-1:0] left_r, left_nxt;
  logic has_r, has_nxt;
  state_t st_r, st_nxt;
  logic [1:0] act_r, act_nxt; logic leg_r, leg_nxt;
  logic [23:0] hz_r, hz_nxt;
  logic [63:0] m_r, m_nxt, acc_r, acc_nxt, fac_r, fac_nxt;
  logic [FB-1:0] k_r, k_nxt;
  logic [LW-1:0] dist_r, dist_nxt;
  logic [COUNT_BITS-1:0] len_r, len_nxt;
  logic [23:0] fo_r, fo_nxt; logic gl_r, gl_nxt, ov_r, ov_nxt;

  logic mul_start, mul_done, div_start, div_done;
  logic [63:0] ma, mb, dn, dd, dq; logic [127:0] mp; logic dsq;

  lfg_mul #(.W(64)) u_mul (.clk, .rst_n, .start(mul_start), .a(ma), .b(mb),
    .done(mul_done), .p(mp));
  lfg_div #(.W(64)) u_div (.clk, .rst_n, .start(div_start), .sqrt_mode(dsq),
    .n(dn), .d(dd), .done(div_done), .q(dq));

  // configuration
  logic [1:0] ridx;
  assign ridx = paddr[3:2];
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_DEFAULT; tpo_r <= '0; mode_r <= '0;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_RATE: rate_r <= pwdata[18:0];
        REG_TIME: tpo_r <= pwdata[23:0];
        REG_MODE: mode_r <= pwdata[1:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (ridx)
      REG_RATE: prdata = {13'd0, rate_r};
      REG_TIME: prdata = {8'd0, tpo_r};
      REG_MODE: prdata = {30'd0, mode_r};
      default:  prdata = '0;
    endcase
  end

  logic accept;
  assign accept = in_valid && !in_stall;
  assign in_stall = (st_r != ST_IDLE) || ov_r;

  // helper combinational values
  logic [23:0] hzc; logic [4:0] msb; logic [63:0] mn;
  logic [42:0] tr; logic [127:0] prod; logic lrem; logic [COUNT_BITS-1:0] q;
  logic up; logic allowed; logic [18:0] rate_e;
  logic [63:0] accsh; logic [63:0] vr; logic [4:0] ip;

  always_comb begin
    hzc = (hz_r < 24'd256) ? 24'd256 : hz_r;
    msb = 5'd8;
    for (int i = 9; i < 24; i++) if (hzc[i]) msb = 5'(i);
    mn = 64'(hzc) << (5'd31 - msb);
    rate_e = (rate_r == '0) ? RATE_DEFAULT : rate_r;
    tr = 43'(tpo_r) * 43'(rate_e);
    up = tl_r >= cur_r;
    allowed = (mode_r == MODE_ALWAYS) || (mode_r == MODE_LEGATO && leg_r);
    prod = mp;
    lrem = (prod & ((128'd1 << S) - 128'd1)) != '0;
    q = ((prod >> S) >= 128'(CMAX)) ? CMAX :
        COUNT_BITS'(prod >> S) + COUNT_BITS'(lrem);
    ip = 5'(cur_r >> LOG_FRAC_BITS);
    accsh = acc_r << ip;
    vr = (accsh + 64'd4194304) >> 23;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (accept) begin
        if (in_action == ACT_SET || in_action == ACT_TRANS) st_nxt = ST_LOG;
        else st_nxt = ST_EXP;
      end
      ST_LOG:   st_nxt = ST_LOGSQ;
      ST_LOGSQ: if (mul_done && k_r == FB'(1)) begin
        if (act_r == ACT_TRANS && has_r && allowed && tpo_r != '0) st_nxt = ST_LEN;
        else st_nxt = ST_EXP;
      end
      ST_LEN:   if (mul_done) st_nxt = (q <= COUNT_BITS'(1)) ? ST_EXP : ST_DIV;
      ST_DIV:   if (div_done) st_nxt = ST_EXP;
      ST_EXP:   st_nxt = has_r ? ST_EXPSQ : ST_OUT;
      ST_EXPSQ: if (div_done) st_nxt = ST_EXPMUL;
      ST_EXPMUL: if (mul_done || !cur_r[LOG_FRAC_BITS - k_r])
        st_nxt = (k_r == FB'(LOG_FRAC_BITS)) ? ST_OUT : ST_EXPSQ;
      ST_OUT:   st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cur_nxt = cur_r; tgt_nxt = tgt_r; step_nxt = step_r; left_nxt = left_r;
    has_nxt = has_r; act_nxt = act_r; leg_nxt = leg_r; hz_nxt = hz_r;
    m_nxt = m_r; acc_nxt = acc_r; fac_nxt = fac_r; k_nxt = k_r; tl_nxt = tl_r;
    dist_nxt = dist_r; len_nxt = len_r; fo_nxt = fo_r; gl_nxt = gl_r;
    ov_nxt = ov_r && out_stall;
    mul_start = 1'b0; div_start = 1'b0; dsq = 1'b0;
    ma = m_r; mb = m_r; dn = fac_r << 31; dd = '0;
    case (st_r)
      ST_IDLE: if (accept) begin
        act_nxt = in_action; hz_nxt = in_frequency; leg_nxt = in_legato;
        if (in_action == ACT_RESET) begin
          cur_nxt = '0; tgt_nxt = '0; step_nxt = '0; left_nxt = '0; has_nxt = 1'b0;
        end else if (in_action == ACT_NEXT && has_r && left_r != '0) begin
          if (left_r == COUNT_BITS'(1)) begin
            cur_nxt = tgt_r; step_nxt = '0;
          end else begin
            cur_nxt = LW'(cur_r + step_r[LW-1:0]);
          end
          left_nxt = left_r - 1'b1;
        end
      end
      ST_LOG: begin
        m_nxt = mn; tl_nxt = LW'(msb - 5'd8); k_nxt = FB'(LOG_FRAC_BITS);
        ma = mn; mb = mn; mul_start = 1'b1;
      end
      ST_LOGSQ: if (mul_done) begin
        // one fraction bit per squaring
        if (mp[63+31:31] >= 64'h1_0000_0000) begin
          tl_nxt = {tl_r[LW-2:0], 1'b1}; m_nxt = 64'(mp >> 32);
        end else begin
          tl_nxt = {tl_r[LW-2:0], 1'b0}; m_nxt = 64'(mp >> 31);
        end
        if (k_r == FB'(1)) begin
          if (!(act_r == ACT_TRANS && has_r && allowed && tpo_r != '0)) begin
            cur_nxt = {tl_nxt}; tgt_nxt = tl_nxt; step_nxt = '0;
            left_nxt = '0; has_nxt = 1'b1;
          end else begin
            ma = 64'((tl_nxt >= cur_r) ? tl_nxt - cur_r : cur_r - tl_nxt);
            dist_nxt = LW'(ma); mb = 64'(tr); mul_start = 1'b1;
          end
        end else begin
          k_nxt = k_r - 1'b1; ma = m_nxt; mb = m_nxt; mul_start = 1'b1;
        end
      end
      ST_LEN: if (mul_done) begin
        len_nxt = q;
        if (q <= COUNT_BITS'(1)) begin
          cur_nxt = tl_r; tgt_nxt = tl_r; step_nxt = '0; left_nxt = '0;
          has_nxt = 1'b1;
        end else begin
          dn = 64'(dist_r); dd = 64'(q); div_start = 1'b1;
        end
      end
      ST_DIV: if (div_done) begin
        tgt_nxt = tl_r; left_nxt = len_r;
        step_nxt = up ? SW'(dq) : SW'(0) - SW'(dq);
      end
      ST_EXP: begin
        acc_nxt = 64'd1 << 31; fac_nxt = 64'd2 << 31; k_nxt = FB'(1);
        if (has_r) begin
          dn = (64'd2 << 31) << 31; dsq = 1'b1; div_start = 1'b1;
        end
      end
      ST_EXPSQ: if (div_done) begin
        fac_nxt = dq;
        if (cur_r[LOG_FRAC_BITS - k_r]) begin
          ma = acc_r; mb = dq; mul_start = 1'b1;
        end
      end
      ST_EXPMUL: if (mul_done || !cur_r[LOG_FRAC_BITS - k_r]) begin
        if (mul_done) acc_nxt = 64'(mp >> 31);
        if (k_r != FB'(LOG_FRAC_BITS)) begin
          k_nxt = k_r + 1'b1; dn = fac_r << 31; dsq = 1'b1; div_start = 1'b1;
        end
      end
      ST_OUT: begin
        ov_nxt = 1'b1; gl_nxt = has_r && left_r != '0;
        fo_nxt = !has_r ? 24'd0 : (vr > 64'hFFFFFF ? 24'hFFFFFF : vr[23:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ov_r <= 1'b0; has_r <= 1'b0;
      cur_r <= '0; tgt_r <= '0; step_r <= '0; left_r <= '0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt; has_r <= has_nxt;
      cur_r <= cur_nxt; tgt_r <= tgt_nxt; step_r <= step_nxt; left_r <= left_nxt;
    end
    act_r <= act_nxt; leg_r <= leg_nxt; hz_r <= hz_nxt; m_r <= m_nxt;
    acc_r <= acc_nxt; fac_r <= fac_nxt; k_r <= k_nxt; tl_r <= tl_nxt;
    dist_r <= dist_nxt; len_r <= len_nxt; fo_r <= fo_nxt; gl_r <= gl_nxt;
  end

  assign out_valid = ov_r;
  assign out_frequency_out = fo_r;
  assign out_gliding = gl_r;
endmodule

// ===== hdl/lfg_checker.sv =====
// Port-level checker for the glide block, bound to the top level
`include "log_frequency_glide_defines.svh"
module lfg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [23:0] out_frequency_out,
  input logic        out_gliding
);
  // a pending word holds
  `LFG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_frequency_out))
  // a reset word never reports a glide
  `LFG_ASSERT_NOW(a_zero_no_glide, clk, rst_n, out_valid && out_frequency_out == 24'd0, !out_gliding)
  // no new word while a result waits
  `LFG_ASSERT_NOW(a_stall_busy, clk, rst_n, out_valid, in_stall)
  // hold off the input once a word is taken
  `LFG_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
endmodule

bind log_frequency_glide lfg_checker u_lfg_checker (.clk, .rst_n, .in_valid, .in_stall,
  .out_valid, .out_stall, .out_frequency_out, .out_gliding);
